/* sv/acfp_pkg.sv */
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared types and constants of the ASCII CAN frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

   localparam int MAX_DATA_BYTES_DEFAULT = 8;
   localparam int OUT_BYTES              = 8;

   localparam logic [30:0] PERIOD_MAX = 31'h7FFF_FFFF;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_AT     = 8'h40;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] frame_id;
      logic [3:0]  frame_length;
      logic [7:0]  data_byte0;
      logic [7:0]  data_byte1;
      logic [7:0]  data_byte2;
      logic [7:0]  data_byte3;
      logic [7:0]  data_byte4;
      logic [7:0]  data_byte5;
      logic [7:0]  data_byte6;
      logic [7:0]  data_byte7;
      logic [30:0] period_value;
      logic        parse_status;
   } rsp_payload_type;

endpackage

/* sv/acfp_stream_if.sv */
// ----------------------------------------------------------------------------
// acfp_req_if / acfp_rsp_if
// Valid/ready channels for characters in and parsed frames out.
// ----------------------------------------------------------------------------
interface acfp_req_if import acfp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface acfp_rsp_if import acfp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/ascii_can_frame_parser.sv */
// ----------------------------------------------------------------------------
// ascii_can_frame_parser
// Parses '#ID$LEN@DATA/PERIOD' text, one character per request, into a frame.
// One character is taken every cycle unless the input stalls. A character
// is registered on entry, updates the field state in the following cycle,
// and on the character marked end_of_message the frame formed by the parse
// core is loaded into the result register. Input stalls only when a finished
// frame is still waiting in the result register and the next last character
// arrives. Data bytes past the eighth are parsed but not reported.
// ----------------------------------------------------------------------------
module ascii_can_frame_parser import acfp_pkg::*; #(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   acfp_req_if.sink    req_if,
   acfp_rsp_if.source  rsp_if
);

   logic            item_valid;
   req_payload_type item;
   rsp_payload_type frame;
   logic            room;
   logic            advance;
   logic            load;

   assign advance = item_valid && (!item.end_of_message || room);
   assign load    = item_valid && item.end_of_message && room;

   acfp_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   acfp_parse_core #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .item   (item),
      .frame  (frame)
   );

   acfp_rsp_stage u_rsp_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .frame  (frame),
      .room   (room),
      .rsp_if (rsp_if)
   );

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      item_valid && !advance |-> item.end_of_message && rsp_if.valid && !rsp_if.ready)
      else $error("parse stage stalled without a full result register");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_if.ready)
      else $error("empty input register refused a request");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_if.valid)
      else $error("loaded frame not presented");

   a_only_last_loads: assert property (@(posedge clock) disable iff (reset)
      load |-> advance)
      else $error("frame loaded without the core advancing");

endmodule

/* sv/acfp_req_stage.sv */
// ----------------------------------------------------------------------------
// acfp_req_stage
// Input register: holds one request until the parse core takes it.
// ----------------------------------------------------------------------------
module acfp_req_stage import acfp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   acfp_req_if.sink         req_if,
   input  logic             advance,
   output logic             item_valid,
   output req_payload_type  item
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type item_ff;
   logic            take;

   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_if.payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* sv/acfp_parse_core.sv */
// ----------------------------------------------------------------------------
// acfp_parse_core
// Field state machine and accumulators; forms the frame on the last character.
// ----------------------------------------------------------------------------
module acfp_parse_core import acfp_pkg::*; #(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  req_payload_type  item,
   output rsp_payload_type  frame
);

   localparam int LEN_W    = $clog2(MAX_DATA_BYTES + 1);
   localparam int STORE_D  = (MAX_DATA_BYTES < OUT_BYTES) ? MAX_DATA_BYTES : OUT_BYTES;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DATA_BYTES);

   localparam logic [2:0] PH_HASH      = 3'd0;
   localparam logic [2:0] PH_ID        = 3'd1;
   localparam logic [2:0] PH_SEEK_LEN  = 3'd2;
   localparam logic [2:0] PH_LEN       = 3'd3;
   localparam logic [2:0] PH_SEEK_DATA = 3'd4;
   localparam logic [2:0] PH_DATA      = 3'd5;
   localparam logic [2:0] PH_SEEK_PER  = 3'd6;
   localparam logic [2:0] PH_PER       = 3'd7;

   localparam int SEP_DOLLAR = 0;
   localparam int SEP_AT     = 1;
   localparam int SEP_SLASH  = 2;

   logic [2:0]       phase_ff,      phase_in;
   logic [31:0]      id_ff,         id_in;
   logic [LEN_W-1:0] len_ff,        len_in;
   logic [7:0]       store_ff [STORE_D];
   logic [7:0]       store_in [STORE_D];
   logic [LEN_W-1:0] pos_ff,        pos_in;
   logic             pending_ff,    pending_in;
   logic [3:0]       hi_ff,         hi_in;
   logic             first_ok_ff,   first_ok_in;
   logic [30:0]      period_ff,     period_in;
   logic             per_end_ff,    per_end_in;
   logic [2:0]       seen_ff,       seen_in;

   logic [7:0]       c;
   logic             hex_ok;
   logic [3:0]       hex_val;
   logic             dec_ok;
   logic [LEN_W+3:0] len_mul;
   logic [34:0]      per_mul;
   logic [7:0]       pair_byte;
   logic [LEN_W-1:0] pos_inc;
   logic [7:0]       bytes_out [OUT_BYTES];

   assign c = item.character;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign dec_ok  = (c >= 8'h30) && (c <= 8'h39);
   assign len_mul = ({4'd0, len_ff} << 3) + ({4'd0, len_ff} << 1) + (LEN_W+4)'(c[3:0]);
   assign per_mul = ({4'd0, period_ff} << 3) + ({4'd0, period_ff} << 1) + 35'(c[3:0]);
   assign pos_inc = pos_ff + LEN_W'(1);

   always_comb begin
      pair_byte = 8'd0;
      if (first_ok_ff) begin
         pair_byte = hex_ok ? {hi_ff, hex_val} : {4'd0, hi_ff};
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      id_in       = id_ff;
      len_in      = len_ff;
      store_in    = store_ff;
      pos_in      = pos_ff;
      pending_in  = pending_ff;
      hi_in       = hi_ff;
      first_ok_in = first_ok_ff;
      period_in   = period_ff;
      per_end_in  = per_end_ff;
      seen_in     = seen_ff;

      unique case (phase_ff)
         PH_HASH: begin
            phase_in = PH_ID;
         end
         PH_ID, PH_SEEK_LEN: begin
            if (phase_ff == PH_ID && hex_ok) begin
               id_in = {id_ff[27:0], hex_val};
            end else if (c == CHAR_DOLLAR) begin
               seen_in[SEP_DOLLAR] = 1'b1;
               phase_in            = PH_LEN;
            end else begin
               phase_in = PH_SEEK_LEN;
            end
         end
         PH_LEN, PH_SEEK_DATA: begin
            if (phase_ff == PH_LEN && dec_ok) begin
               len_in = (len_mul > (LEN_W+4)'(MAX_DATA_BYTES)) ? LEN_MAX : len_mul[LEN_W-1:0];
            end else if (c == CHAR_AT) begin
               seen_in[SEP_AT] = 1'b1;
               pos_in          = '0;
               pending_in      = 1'b0;
               hi_in           = 4'd0;
               first_ok_in     = 1'b0;
               phase_in        = (len_ff == '0) ? PH_SEEK_PER : PH_DATA;
            end else begin
               phase_in = PH_SEEK_DATA;
            end
         end
         PH_DATA: begin
            if (c == CHAR_SLASH) begin
               seen_in[SEP_SLASH] = 1'b1;
               phase_in           = PH_PER;
            end else if (!pending_ff) begin
               first_ok_in = hex_ok;
               hi_in       = hex_ok ? hex_val : 4'd0;
               pending_in  = 1'b1;
            end else begin
               for (int i = 0; i < STORE_D; i++) begin
                  if (pos_ff == LEN_W'(i)) begin
                     store_in[i] = pair_byte;
                  end
               end
               pos_in      = pos_inc;
               pending_in  = 1'b0;
               hi_in       = 4'd0;
               first_ok_in = 1'b0;
               if (pos_inc >= len_ff) begin
                  phase_in = PH_SEEK_PER;
               end
            end
         end
         PH_SEEK_PER: begin
            if (c == CHAR_SLASH) begin
               seen_in[SEP_SLASH] = 1'b1;
               phase_in           = PH_PER;
            end
         end
         default: begin
            if (!per_end_ff) begin
               if (dec_ok) begin
                  period_in = (per_mul > 35'(PERIOD_MAX)) ? PERIOD_MAX : per_mul[30:0];
               end else begin
                  per_end_in = 1'b1;
               end
            end
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < OUT_BYTES; i++) begin
         bytes_out[i] = 8'd0;
      end
      for (int i = 0; i < STORE_D; i++) begin
         bytes_out[i] = store_in[i];
      end
   end

   always_comb begin
      frame.frame_id     = id_in;
      frame.frame_length = 4'(len_in);
      frame.data_byte0   = bytes_out[0];
      frame.data_byte1   = bytes_out[1];
      frame.data_byte2   = bytes_out[2];
      frame.data_byte3   = bytes_out[3];
      frame.data_byte4   = bytes_out[4];
      frame.data_byte5   = bytes_out[5];
      frame.data_byte6   = bytes_out[6];
      frame.data_byte7   = bytes_out[7];
      frame.period_value = period_in;
      frame.parse_status = !(&seen_in);
   end

   // Clear everything after the last character of a message.
   always_ff @(posedge clock) begin
      if (reset || (enable && item.end_of_message)) begin
         phase_ff    <= PH_HASH;
         id_ff       <= '0;
         len_ff      <= '0;
         pos_ff      <= '0;
         pending_ff  <= 1'b0;
         hi_ff       <= 4'd0;
         first_ok_ff <= 1'b0;
         period_ff   <= '0;
         per_end_ff  <= 1'b0;
         seen_ff     <= '0;
         for (int i = 0; i < STORE_D; i++) begin
            store_ff[i] <= 8'd0;
         end
      end else if (enable) begin
         phase_ff    <= phase_in;
         id_ff       <= id_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
         pending_ff  <= pending_in;
         hi_ff       <= hi_in;
         first_ok_ff <= first_ok_in;
         period_ff   <= period_in;
         per_end_ff  <= per_end_in;
         seen_ff     <= seen_in;
         store_ff    <= store_in;
      end
   end

endmodule

/* sv/acfp_rsp_stage.sv */
// ----------------------------------------------------------------------------
// acfp_rsp_stage
// Result register: holds one frame until the consumer takes it.
// ----------------------------------------------------------------------------
module acfp_rsp_stage import acfp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  rsp_payload_type  frame,
   output logic             room,
   acfp_rsp_if.source       rsp_if
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type frame_ff;

   assign room = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame;
      end
   end

   assign rsp_if.valid   = valid_ff;
   assign rsp_if.payload = frame_ff;

endmodule

/* verif/acfp_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfp_frame_checker
// Watches the character and frame channels of the ASCII CAN frame parser,
// parses every accepted character with its own copy of the field state and
// compares each delivered frame, field by field, with the oldest predicted
// frame. Reports a running mismatch count and the number of frames in flight.
// ----------------------------------------------------------------------------
module acfp_frame_checker import acfp_pkg::*; #(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   acfp_req_if  req_mon,
   acfp_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   frames_pending,
   output int   frames_checked,
   output int   frames_incomplete
);

   localparam int MAX_REPORTS = 10;

   localparam logic [2:0] SAW_DOLLAR = 3'b001;
   localparam logic [2:0] SAW_AT     = 3'b010;
   localparam logic [2:0] SAW_SLASH  = 3'b100;
   localparam logic [2:0] SAW_ALL    = SAW_DOLLAR | SAW_AT | SAW_SLASH;

   localparam logic STATUS_COMPLETE          = 1'b0;
   localparam logic STATUS_MISSING_SEPARATOR = 1'b1;

   typedef enum logic [2:0] {
      WAIT_HASH,
      IN_ID,
      SEEK_LEN,
      IN_LEN,
      SEEK_DATA,
      IN_DATA,
      SEEK_PERIOD,
      IN_PERIOD
   } parse_phase_type;

   parse_phase_type phase;
   logic [31:0]     id_accum;
   logic [3:0]      length_accum;
   logic [7:0]      data_bytes [MAX_DATA_BYTES];
   int              byte_position;
   logic            pair_pending;
   logic            first_valid;
   logic [3:0]      first_nibble;
   int unsigned     period_accum;
   logic            period_ended;
   logic [2:0]      separators;

   rsp_payload_type expected_frames [$];

   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic int dec_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      return -1;
   endfunction

   task automatic clear_parse_state();
      phase        = WAIT_HASH;
      id_accum     = '0;
      length_accum = '0;
      foreach (data_bytes[i]) data_bytes[i] = 8'h00;
      byte_position = 0;
      pair_pending  = 1'b0;
      first_valid   = 1'b0;
      first_nibble  = 4'h0;
      period_accum  = 0;
      period_ended  = 1'b0;
      separators    = '0;
   endtask

   task automatic open_data_field();
      separators    = separators | SAW_AT;
      byte_position = 0;
      pair_pending  = 1'b0;
      first_valid   = 1'b0;
      first_nibble  = 4'h0;
      phase         = (length_accum == 0) ? SEEK_PERIOD : IN_DATA;
   endtask

   task automatic absorb_character(input logic [7:0] c);
      int          hex_val;
      int          dec_val;
      int          length_sum;
      int unsigned period_limit;
      logic [7:0]  pair_byte;
      hex_val = hex_digit_value(c);
      dec_val = dec_digit_value(c);
      case (phase)
         WAIT_HASH: phase = IN_ID;
         IN_ID: begin
            if (hex_val >= 0) begin
               id_accum = {id_accum[27:0], hex_val[3:0]};
            end else if (c == CHAR_DOLLAR) begin
               separators = separators | SAW_DOLLAR;
               phase      = IN_LEN;
            end else begin
               phase = SEEK_LEN;
            end
         end
         SEEK_LEN: begin
            if (c == CHAR_DOLLAR) begin
               separators = separators | SAW_DOLLAR;
               phase      = IN_LEN;
            end
         end
         IN_LEN: begin
            if (dec_val >= 0) begin
               length_sum   = int'(length_accum) * 10 + dec_val;
               length_accum = (length_sum > MAX_DATA_BYTES) ? 4'(MAX_DATA_BYTES)
                                                            : 4'(length_sum);
            end else if (c == CHAR_AT) begin
               open_data_field();
            end else begin
               phase = SEEK_DATA;
            end
         end
         SEEK_DATA: begin
            if (c == CHAR_AT) open_data_field();
         end
         IN_DATA: begin
            if (c == CHAR_SLASH) begin
               separators = separators | SAW_SLASH;
               phase      = IN_PERIOD;
            end else if (!pair_pending) begin
               pair_pending = 1'b1;
               first_valid  = (hex_val >= 0);
               first_nibble = first_valid ? hex_val[3:0] : 4'h0;
            end else begin
               pair_byte = 8'h00;
               if (first_valid) begin
                  pair_byte = (hex_val >= 0) ? {first_nibble, hex_val[3:0]}
                                             : {4'h0, first_nibble};
               end
               if (byte_position < MAX_DATA_BYTES) data_bytes[byte_position] = pair_byte;
               byte_position++;
               pair_pending = 1'b0;
               first_valid  = 1'b0;
               if (byte_position >= int'(length_accum)) phase = SEEK_PERIOD;
            end
         end
         SEEK_PERIOD: begin
            if (c == CHAR_SLASH) begin
               separators = separators | SAW_SLASH;
               phase      = IN_PERIOD;
            end
         end
         default: begin
            if (!period_ended) begin
               if (dec_val >= 0) begin
                  period_limit = (32'(PERIOD_MAX) - dec_val) / 10;
                  if (period_accum > period_limit) period_accum = 32'(PERIOD_MAX);
                  else period_accum = period_accum * 10 + dec_val;
               end else begin
                  period_ended = 1'b1;
               end
            end
         end
      endcase
   endtask

   function automatic logic [7:0] reported_byte(input int index);
      if (index < MAX_DATA_BYTES) return data_bytes[index];
      return 8'h00;
   endfunction

   function automatic rsp_payload_type parsed_frame();
      rsp_payload_type f;
      f.frame_id     = id_accum;
      f.frame_length = length_accum;
      f.data_byte0   = reported_byte(0);
      f.data_byte1   = reported_byte(1);
      f.data_byte2   = reported_byte(2);
      f.data_byte3   = reported_byte(3);
      f.data_byte4   = reported_byte(4);
      f.data_byte5   = reported_byte(5);
      f.data_byte6   = reported_byte(6);
      f.data_byte7   = reported_byte(7);
      f.period_value = period_accum[30:0];
      f.parse_status = (separators == SAW_ALL) ? STATUS_COMPLETE : STATUS_MISSING_SEPARATOR;
      return f;
   endfunction

   task automatic compare_field(input string field_name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("frame %0d %s: expected 0x%0h, got 0x%0h",
                     frames_checked, field_name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         clear_parse_state();
         expected_frames.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected frame with id 0x%0h, nothing pending", got.frame_id);
               end
            end else begin
               want = expected_frames.pop_front();
               frames_checked++;
               if (want.parse_status == STATUS_MISSING_SEPARATOR) frames_incomplete++;
               compare_field("frame_id", want.frame_id, got.frame_id);
               compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
               compare_field("data_byte0", 32'(want.data_byte0), 32'(got.data_byte0));
               compare_field("data_byte1", 32'(want.data_byte1), 32'(got.data_byte1));
               compare_field("data_byte2", 32'(want.data_byte2), 32'(got.data_byte2));
               compare_field("data_byte3", 32'(want.data_byte3), 32'(got.data_byte3));
               compare_field("data_byte4", 32'(want.data_byte4), 32'(got.data_byte4));
               compare_field("data_byte5", 32'(want.data_byte5), 32'(got.data_byte5));
               compare_field("data_byte6", 32'(want.data_byte6), 32'(got.data_byte6));
               compare_field("data_byte7", 32'(want.data_byte7), 32'(got.data_byte7));
               compare_field("period_value", 32'(want.period_value), 32'(got.period_value));
               compare_field("parse_status", 32'(want.parse_status), 32'(got.parse_status));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_character(req_mon.payload.character);
            if (req_mon.payload.end_of_message) begin
               expected_frames.push_back(parsed_frame());
               clear_parse_state();
            end
         end
      end
      frames_pending = expected_frames.size();
   end

endmodule

/* verif/ascii_can_frame_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_can_frame_parser_test
// Drives '#ID$LEN@DATA/PERIOD' messages into the parser one character per
// request: a directed set of corner messages, then random well-formed and
// broken messages plus noise, with random gaps, random result stalls and one
// long result hold-off. A checker beside the parser predicts every frame.
// ----------------------------------------------------------------------------
module ascii_can_frame_parser_test;
   import acfp_pkg::*;

   localparam int HALF_PERIOD_NS     = 6;
   localparam int RESET_CYCLES       = 5;
   localparam int RANDOM_ITEMS       = 950;
   localparam int TAIL_ITEMS         = 150;
   localparam int HOLD_OFF_CYCLES    = 120;
   localparam int PRESSURE_MESSAGES  = 12;
   localparam int DRAIN_CYCLES       = 10;
   localparam int LIMIT_NS           = 6_000_000;

   logic clock = 1'b0;
   logic reset;

   acfp_req_if req_if();
   acfp_rsp_if rsp_if();

   int mismatch_count;
   int frames_pending;
   int frames_checked;
   int frames_incomplete;

   logic [7:0] message_chars [$];
   int         chars_sent;
   int         frames_sent;
   int         idle_odds;
   bit         hold_off;
   bit         quiet_tail;

   always #(HALF_PERIOD_NS) clock = ~clock;

   ascii_can_frame_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   acfp_frame_checker frame_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_if),
      .rsp_mon           (rsp_if),
      .mismatch_count    (mismatch_count),
      .frames_pending    (frames_pending),
      .frames_checked    (frames_checked),
      .frames_incomplete (frames_incomplete)
   );

   task automatic send_char(input logic [7:0] ch, input logic last_char);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= {ch, last_char};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_message(input bit with_end);
      foreach (message_chars[i]) begin
         send_char(message_chars[i], with_end && (i == message_chars.size() - 1));
      end
      if (with_end) frames_sent++;
   endtask

   task automatic push_text(input string text);
      for (int i = 0; i < text.len(); i++) message_chars.push_back(text[i]);
   endtask

   task automatic send_text(input string text, input bit with_end);
      message_chars.delete();
      push_text(text);
      send_message(with_end);
   endtask

   task automatic push_random_chars(input int count);
      repeat (count) message_chars.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic push_hex_digit();
      int nibble;
      nibble = $urandom_range(0, 15);
      if (nibble < 10) message_chars.push_back(8'("0" + nibble));
      else if ($urandom_range(0, 1) == 1) message_chars.push_back(8'("A" + nibble - 10));
      else message_chars.push_back(8'("a" + nibble - 10));
   endtask

   task automatic compose_message();
      int shape;
      int drop_mark;
      int length_text;
      int pair_chars;
      int digit_count;
      shape = $urandom_range(0, 9);
      message_chars.delete();
      if (shape >= 8) begin
         push_random_chars($urandom_range(1, 20));
         return;
      end
      drop_mark = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 7) == 0) push_random_chars(1);
      else push_text("#");
      repeat ($urandom_range(0, 10)) push_hex_digit();
      if ($urandom_range(0, 7) == 0) push_random_chars($urandom_range(1, 3));
      if (drop_mark != 1) message_chars.push_back(CHAR_DOLLAR);
      length_text = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 120) : $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) push_text("0");
      push_text($sformatf("%0d", length_text));
      if ($urandom_range(0, 9) == 0) push_random_chars($urandom_range(1, 3));
      if (drop_mark != 2) message_chars.push_back(CHAR_AT);
      pair_chars = 2 * ((length_text > OUT_BYTES) ? OUT_BYTES : length_text);
      case ($urandom_range(0, 7))
         0: pair_chars = $urandom_range(0, pair_chars);
         1: pair_chars = pair_chars + $urandom_range(1, 5);
         default: ;
      endcase
      repeat (pair_chars) begin
         if ($urandom_range(0, 11) == 0) push_random_chars(1);
         else push_hex_digit();
      end
      if (drop_mark != 3) message_chars.push_back(CHAR_SLASH);
      digit_count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
      repeat (digit_count) message_chars.push_back(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 7) == 0) push_random_chars($urandom_range(1, 3));
   endtask

   initial begin
      int random_start;
      bit pressure_done;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      idle_odds      = 0;
      hold_off       = 1'b0;
      quiet_tail     = 1'b0;
      pressure_done  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("#123$2@A5B6/100", 1'b1);
      send_text("#FFFFFFFF$8@0123456789abcdef/2147483647", 1'b1);
      send_text("#123456789ABC$0@/5", 1'b1);
      send_text("#1$99@1122334455667788/99999999999", 1'b1);
      send_text("#7$08@zz1g/0", 1'b1);
      send_text("#5$4@AB/77", 1'b1);
      send_text("#5 $2@1234/9", 1'b1);
      send_text("#0x1F$1@ff/-5", 1'b1);
      send_text("#12@3$1@44/6", 1'b1);
      send_text("#12@3/4", 1'b1);
      send_text("#AB$3/12", 1'b1);
      send_text("#AB$1@CD", 1'b1);
      send_text("X", 1'b1);
      send_text("#$@/", 1'b1);
      message_chars = '{"#", "1", 8'h00, "$", "1", "@", "2", 8'h00, "/", "3"};
      send_message(1'b1);
      send_text("#1$2@112233/4", 1'b1);
      send_text("#1$1@a", 1'b1);
      send_text("Q9$", 1'b0);
      send_text("#1$1@22/3", 1'b1);
      send_text("#1$2@3 /5 ", 1'b1);

      random_start = chars_sent;
      while (chars_sent - random_start < RANDOM_ITEMS) begin
         if (!pressure_done && chars_sent - random_start >= RANDOM_ITEMS / 2) begin
            pressure_done = 1'b1;
            idle_odds     = 0;
            hold_off      = 1'b1;
            wait (!hold_off);
            repeat (PRESSURE_MESSAGES) begin
               message_chars.delete();
               push_text("#");
               push_hex_digit();
               send_message(1'b1);
            end
         end
         if (chars_sent - random_start >= RANDOM_ITEMS - TAIL_ITEMS) begin
            idle_odds  = 0;
            quiet_tail = 1'b1;
         end else if (frames_sent % 8 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_odds = 0;
               1: idle_odds = 3;
               default: idle_odds = 10;
            endcase
         end
         compose_message();
         send_message($urandom_range(0, 15) != 0);
      end
      if (message_chars.size() == 0 || frames_pending == 0) send_text("#1$0@/1", 1'b1);
      else send_text("#", 1'b1);

      req_if.valid <= 1'b0;
      wait (frames_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d characters in %0d frames, with gaps, stalls and a %0d-cycle hold-off",
               chars_sent, frames_sent, HOLD_OFF_CYCLES);
      $display("compared %0d frames, %0d of them missing a separator, %0d mismatches",
               frames_checked, frames_incomplete, mismatch_count);
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout: %0d frames still pending", frames_pending);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
